// ===== hw/rtl/abkf_pkg.sv =====
// shared types and constants for the angle/bias kalman filter
package abkf_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_W = 17;

  localparam logic [1:0] REG_TIME_STEP     = 2'd0;
  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd1;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd2;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd3;

  localparam logic [CFG_W-1:0] TIME_STEP_RST     = 17'd1311;
  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST   = 17'd66;
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST    = 17'd197;
  localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = 17'd1966;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  // request to the shared arithmetic unit
  typedef struct packed {
    logic         start;
    alu_op_t      op;
    logic [31:0]  a;
    logic [31:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic         done;
    logic [31:0]  res;
  } alu_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

// ===== hw/rtl/abkf_alu.sv =====
// shared saturating add/sub, rounding multiply and bit-serial divide
module abkf_alu #(
  parameter int FRAC_BITS = abkf_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  abkf_pkg::alu_req_t req,
  output abkf_pkg::alu_rsp_t rsp
);
  localparam int NW = 32 + FRAC_BITS;   // dividend magnitude width
  localparam int CW = $clog2(NW + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [31:0]       res_r, res_nxt;
  abkf_pkg::alu_op_t op_r, op_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [NW-1:0]     quo_r, quo_nxt;     // dividend shifts out, quotient in
  logic [32:0]       rem_r, rem_nxt;
  logic [31:0]       den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  logic signed [65:0] sum;
  logic signed [65:0] rnd;
  logic [32:0]        trial;
  logic [32:0]        shifted;
  logic signed [65:0] q_signed;
  logic [31:0]        amag;
  logic [31:0]        bmag;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    op_nxt   = op_r;
    prod_nxt = prod_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    sum      = '0;
    rnd      = '0;
    trial    = '0;
    shifted  = '0;
    q_signed = '0;
    amag     = req.a[31] ? (~req.a + 32'd1) : req.a;
    bmag     = req.b[31] ? (~req.b + 32'd1) : req.b;
    if (!busy_r && req.start) begin
      op_nxt = req.op;
      unique case (req.op)
        abkf_pkg::OP_ADD: begin
          sum      = 66'(signed'(req.a)) + 66'(signed'(req.b));
          res_nxt  = abkf_pkg::sat32(sum);
          done_nxt = 1'b1;
        end
        abkf_pkg::OP_SUB: begin
          sum      = 66'(signed'(req.a)) - 66'(signed'(req.b));
          res_nxt  = abkf_pkg::sat32(sum);
          done_nxt = 1'b1;
        end
        abkf_pkg::OP_MUL: begin
          prod_nxt = signed'(req.a) * signed'(req.b);
          busy_nxt = 1'b1;
        end
        abkf_pkg::OP_DIV: begin
          if (req.b == 32'd0) begin
            res_nxt  = '0;
            done_nxt = 1'b1;
          end else begin
            quo_nxt  = {amag, {FRAC_BITS{1'b0}}};
            rem_nxt  = '0;
            den_nxt  = bmag;
            neg_nxt  = req.a[31] ^ req.b[31];
            cnt_nxt  = CW'(NW);
            busy_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (busy_r) begin
      if (op_r == abkf_pkg::OP_MUL) begin
        // round half up, then arithmetic shift is a floor
        rnd      = (66'(prod_r) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        res_nxt  = abkf_pkg::sat32(rnd);
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        // one quotient bit per cycle
        shifted = {rem_r[31:0], quo_r[NW-1]};
        trial   = shifted - {1'b0, den_r};
        if (!trial[32]) begin
          rem_nxt = trial;
          quo_nxt = {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = shifted;
          quo_nxt = {quo_r[NW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          q_signed = neg_r ? -66'(signed'({1'b0, quo_nxt}))
                           : 66'(signed'({1'b0, quo_nxt}));
          res_nxt  = abkf_pkg::sat32(q_signed);
          done_nxt = 1'b1;
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    res_r  <= res_nxt;
    op_r   <= op_nxt;
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;
endmodule

// ===== hw/rtl/angle_bias_kalman_filter_core.sv =====
// top level: sequencer driving the shared arithmetic unit through one filter step
// each filter step runs 29 ops through the unit, each issued and then awaited:
//   add/sub (17 of them), multiply (10) or 48-step divide (2)
// in_stall is high from accept until the result is taken, so a new item is
//   accepted only after the previous result has been taken
// reset: synchronous active-low; estimates and covariance clear, registers
//   take their defaults
module angle_bias_kalman_filter_core #(
  parameter int FRAC_BITS = abkf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_measured_angle,
  input  logic [31:0] in_measured_rate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_angle_estimate,
  output logic [31:0] out_bias_estimate,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [abkf_pkg::CFG_W-1:0] cfg_data
);
  localparam int NSTEP = 29;
  localparam int SW = $clog2(NSTEP);

  // working registers
  typedef enum logic [3:0] {
    R_MA, R_MR, R_ANG, R_BIAS, R_P00, R_P01, R_P10, R_P11,
    R_T0, R_T1, R_DP, R_Y, R_S, R_K0, R_K1, R_RES
  } reg_id_t;

  logic [31:0] rf_r [16];
  logic [abkf_pkg::CFG_W-1:0] dt_r, qa_r, qb_r, rn_r;
  abkf_pkg::state_t state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  abkf_pkg::alu_req_t req;
  abkf_pkg::alu_rsp_t rsp;

  // micro-program entry: op, source a, source b, destination
  // use_ca/use_cb replace a source with a config register chosen by the step
  abkf_pkg::alu_op_t m_op;
  reg_id_t m_a, m_b, m_d;
  logic [31:0] cfg_a, cfg_b;
  logic use_ca, use_cb;

  always_comb begin
    m_op = abkf_pkg::OP_ADD; m_a = R_MA; m_b = R_MA; m_d = R_RES;
    use_ca = 1'b0; use_cb = 1'b0;
    cfg_a = {15'd0, dt_r}; cfg_b = {15'd0, dt_r};
    unique case (step_r)
      5'd0:  begin m_op = abkf_pkg::OP_SUB; m_a = R_MR;  m_b = R_BIAS; m_d = R_T0; end
      5'd1:  begin m_op = abkf_pkg::OP_MUL; m_a = R_T0;  use_cb = 1'b1; m_d = R_T0; end
      5'd2:  begin m_op = abkf_pkg::OP_ADD; m_a = R_ANG; m_b = R_T0;   m_d = R_ANG; end
      5'd3:  begin m_op = abkf_pkg::OP_MUL; use_ca = 1'b1; m_b = R_P11; m_d = R_DP; end
      5'd4:  begin m_op = abkf_pkg::OP_SUB; m_a = R_DP;  m_b = R_P01;  m_d = R_T0; end
      5'd5:  begin m_op = abkf_pkg::OP_SUB; m_a = R_T0;  m_b = R_P10;  m_d = R_T0; end
      5'd6:  begin m_op = abkf_pkg::OP_ADD; m_a = R_T0;  use_cb = 1'b1;
                   cfg_b = {15'd0, qa_r}; m_d = R_T0; end
      5'd7:  begin m_op = abkf_pkg::OP_MUL; use_ca = 1'b1; m_b = R_T0; m_d = R_T0; end
      5'd8:  begin m_op = abkf_pkg::OP_ADD; m_a = R_P00; m_b = R_T0;   m_d = R_P00; end
      5'd9:  begin m_op = abkf_pkg::OP_SUB; m_a = R_P01; m_b = R_DP;   m_d = R_P01; end
      5'd10: begin m_op = abkf_pkg::OP_SUB; m_a = R_P10; m_b = R_DP;   m_d = R_P10; end
      5'd11: begin m_op = abkf_pkg::OP_MUL; use_ca = 1'b1; cfg_a = {15'd0, qb_r};
                   use_cb = 1'b1; m_d = R_T0; end
      5'd12: begin m_op = abkf_pkg::OP_ADD; m_a = R_P11; m_b = R_T0;   m_d = R_P11; end
      5'd13: begin m_op = abkf_pkg::OP_SUB; m_a = R_MA;  m_b = R_ANG;  m_d = R_Y; end
      5'd14: begin m_op = abkf_pkg::OP_ADD; m_a = R_P00; use_cb = 1'b1;
                   cfg_b = {15'd0, rn_r}; m_d = R_S; end
      5'd15: begin m_op = abkf_pkg::OP_DIV; m_a = R_P00; m_b = R_S;    m_d = R_K0; end
      5'd16: begin m_op = abkf_pkg::OP_DIV; m_a = R_P10; m_b = R_S;    m_d = R_K1; end
      5'd17: begin m_op = abkf_pkg::OP_MUL; m_a = R_K0;  m_b = R_Y;    m_d = R_T0; end
      5'd18: begin m_op = abkf_pkg::OP_ADD; m_a = R_ANG; m_b = R_T0;   m_d = R_ANG; end
      5'd19: begin m_op = abkf_pkg::OP_MUL; m_a = R_K1;  m_b = R_Y;    m_d = R_T0; end
      5'd20: begin m_op = abkf_pkg::OP_ADD; m_a = R_BIAS; m_b = R_T0;  m_d = R_BIAS; end
      // products from old p00/p01 first, then the subtracts
      5'd21: begin m_op = abkf_pkg::OP_MUL; m_a = R_K0;  m_b = R_P00;  m_d = R_T0; end
      5'd22: begin m_op = abkf_pkg::OP_MUL; m_a = R_K0;  m_b = R_P01;  m_d = R_T1; end
      5'd23: begin m_op = abkf_pkg::OP_MUL; m_a = R_K1;  m_b = R_P00;  m_d = R_DP; end
      5'd24: begin m_op = abkf_pkg::OP_MUL; m_a = R_K1;  m_b = R_P01;  m_d = R_Y; end
      5'd25: begin m_op = abkf_pkg::OP_SUB; m_a = R_P00; m_b = R_T0;   m_d = R_P00; end
      5'd26: begin m_op = abkf_pkg::OP_SUB; m_a = R_P01; m_b = R_T1;   m_d = R_P01; end
      5'd27: begin m_op = abkf_pkg::OP_SUB; m_a = R_P10; m_b = R_DP;   m_d = R_P10; end
      5'd28: begin m_op = abkf_pkg::OP_SUB; m_a = R_P11; m_b = R_Y;    m_d = R_P11; end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      abkf_pkg::ST_IDLE: if (in_valid) begin
        state_nxt = abkf_pkg::ST_ISSUE;
        step_nxt  = '0;
      end
      abkf_pkg::ST_ISSUE: state_nxt = abkf_pkg::ST_WAIT;
      abkf_pkg::ST_WAIT: if (rsp.done) begin
        if (step_r == SW'(NSTEP - 1)) state_nxt = abkf_pkg::ST_OUT;
        else begin
          state_nxt = abkf_pkg::ST_ISSUE;
          step_nxt  = step_r + SW'(1);
        end
      end
      abkf_pkg::ST_OUT: if (!out_stall) state_nxt = abkf_pkg::ST_IDLE;
      default: state_nxt = abkf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.start = (state_r == abkf_pkg::ST_ISSUE);
    req.op    = m_op;
    req.a     = use_ca ? cfg_a : rf_r[m_a];
    req.b     = use_cb ? cfg_b : rf_r[m_b];
    in_stall  = (state_r != abkf_pkg::ST_IDLE);
    out_valid = (state_r == abkf_pkg::ST_OUT);
    cfg_ready = (state_r == abkf_pkg::ST_IDLE);
  end

  abkf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= abkf_pkg::ST_IDLE;
      step_r  <= '0;
      dt_r    <= abkf_pkg::TIME_STEP_RST;
      qa_r    <= abkf_pkg::ANGLE_NOISE_RST;
      qb_r    <= abkf_pkg::BIAS_NOISE_RST;
      rn_r    <= abkf_pkg::MEASURE_NOISE_RST;
      rf_r[R_ANG]  <= '0;
      rf_r[R_BIAS] <= '0;
      rf_r[R_P00]  <= '0;
      rf_r[R_P01]  <= '0;
      rf_r[R_P10]  <= '0;
      rf_r[R_P11]  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          abkf_pkg::REG_TIME_STEP:     dt_r <= cfg_data;
          abkf_pkg::REG_ANGLE_NOISE:   qa_r <= cfg_data;
          abkf_pkg::REG_BIAS_NOISE:    qb_r <= cfg_data;
          abkf_pkg::REG_MEASURE_NOISE: rn_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == abkf_pkg::ST_IDLE && in_valid) begin
        rf_r[R_MA] <= in_measured_angle;
        rf_r[R_MR] <= in_measured_rate;
      end
      if (state_r == abkf_pkg::ST_WAIT && rsp.done) rf_r[m_d] <= rsp.res;
    end
  end

  assign out_angle_estimate = rf_r[R_ANG];
  assign out_bias_estimate  = rf_r[R_BIAS];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_angle_estimate))
    else $error("result changed while held");
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != abkf_pkg::ST_IDLE |-> !cfg_ready)
    else $error("config open while busy");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> !req.start)
    else $error("alu issued twice in a row");
endmodule
